// ===== hw/rtl/hue_rotation_color_generator_macros.svh =====
// Assertion macros used by the checker file.
`ifndef HUE_ROTATION_COLOR_GENERATOR_MACROS_SVH
`define HUE_ROTATION_COLOR_GENERATOR_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define HRCG_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hrcg assertion failed");

// Next-cycle implication, checked during reset as well.
`define HRCG_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("hrcg assertion failed");

`endif

// ===== hw/rtl/hrcg_pkg.sv =====
package hrcg_pkg;

   localparam int TIME_W            = 64;
   localparam int PCT_W             = 7;
   localparam int SQ_W              = 14;
   localparam int CH_W              = 8;
   localparam int CSR_IDX_W         = 2;
   localparam int HUE_FRAC_BITS_DEF = 16;

   localparam logic [PCT_W-1:0] PCT_MAX        = 7'd100;
   localparam logic [PCT_W-1:0] BRIGHT_RESET   = 7'd100;
   localparam logic [SQ_W-1:0]  SPEED_SQ_RESET = 14'd2500;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SPEED  = 2'd0,
      CSR_BRIGHT = 2'd1,
      CSR_START  = 2'd2
   } csr_index_type;

   // Reduction by the hue period of 10^11 = 5^11 * 2^11.
   localparam int M_W        = 37;
   localparam int RES_W      = 38;
   localparam int DIV_DROP   = 36;
   localparam int RECIP_W    = 31;
   localparam int RECIP_SHIFT = 31;
   localparam int POW5_W     = 26;
   localparam int POW2_EXP   = 11;
   localparam int DIV_STAGES = 3;

   localparam logic [M_W-1:0]     TEN_POW_11 = 37'd100000000000;
   localparam logic [RECIP_W-1:0] RECIP_M    = 31'd1475739525;
   localparam logic [POW5_W-1:0]  POW5_11    = 26'd48828125;

   localparam int DEG_W = 9;
   localparam logic [DEG_W-1:0] DEG_FULL = 9'd360;
   localparam logic [DEG_W-1:0] DEG_SECTOR = 9'd60;

   localparam int Z_W     = 14;
   localparam int SCALE_W = 15;

   localparam logic [10:0] SECTOR_RECIP  = 11'd1093;
   localparam int          SECTOR_SHIFT  = 16;
   localparam logic [14:0] DIV60_RECIP   = 15'd17477;
   localparam int          DIV60_SHIFT   = 20;
   localparam logic [14:0] DIV100_RECIP  = 15'd20972;
   localparam int          DIV100_SHIFT  = 21;

   localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

   localparam int PIPE_LATENCY = 20;

   function automatic logic [PCT_W-1:0] sat_pct(input logic [PCT_W-1:0] v);
      return (v > PCT_MAX) ? PCT_MAX : v;
   endfunction

endpackage

// ===== hw/rtl/hrcg_div.sv =====
module hrcg_div #(
   parameter int XW = hrcg_pkg::TIME_W
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [XW-1:0]                  x_in,
   output logic                           out_valid,
   output logic [XW-hrcg_pkg::DIV_DROP-1:0] q_out,
   output logic [hrcg_pkg::M_W-1:0]       r_out
);
   import hrcg_pkg::*;

   localparam int QW   = XW - DIV_DROP;
   localparam int PW   = QW + RECIP_W;
   localparam int MW   = QW + POW5_W;
   localparam int QM_W = RES_W - POW2_EXP;

   logic            va_ff, vb_ff, vc_ff;
   logic [PW-1:0]   est_prod;
   logic [QW-1:0]   q_a_in, q_a_ff, q_b_ff, q_c_in, q_c_ff;
   logic [RES_W-1:0] x_a_ff, x_b_ff;
   logic [MW-1:0]   qm_prod;
   logic [QM_W-1:0] qm_b_in, qm_b_ff;
   logic [RES_W-1:0] r_raw;
   logic            fix;
   logic [M_W-1:0]  r_c_in, r_c_ff;

   // The quotient estimate is low by at most one, so one correction step follows.
   assign est_prod = PW'(x_in[XW-1:DIV_DROP]) * PW'(RECIP_M);
   assign q_a_in   = est_prod[PW-1:RECIP_SHIFT];

   assign qm_prod = MW'(q_a_ff) * MW'(POW5_11);
   assign qm_b_in = qm_prod[QM_W-1:0];

   assign r_raw  = x_b_ff - {qm_b_ff, {POW2_EXP{1'b0}}};
   assign fix    = (r_raw >= RES_W'(TEN_POW_11));
   assign r_c_in = fix ? M_W'(r_raw - RES_W'(TEN_POW_11)) : M_W'(r_raw);
   assign q_c_in = q_b_ff + QW'(fix);

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      q_a_ff  <= q_a_in;
      x_a_ff  <= x_in[RES_W-1:0];
      q_b_ff  <= q_a_ff;
      qm_b_ff <= qm_b_in;
      x_b_ff  <= x_a_ff;
      q_c_ff  <= q_c_in;
      r_c_ff  <= r_c_in;
   end

   assign out_valid = vc_ff;
   assign q_out     = q_c_ff;
   assign r_out     = r_c_ff;

endmodule

// ===== hw/rtl/hue_rotation_color_generator.sv =====
// Hue rotation color generator.
// A word is taken on req_now_time_us at each clock edge where req_start is high and
// busy is low. busy is always low: the pipeline takes a new word in every cycle.
// Each word gives one color, shown on rsp_red_level, rsp_green_level and
// rsp_blue_level for one cycle with rsp_valid high. Throughput is one word per
// cycle; the pipeline is made of the elapsed-time register, four 3-stage
// reductions by the hue period, the two multiply stages between them and five
// stages of color conversion and brightness scaling.
// The csr port writes speed (index 0), brightness (index 1) and the 64-bit start
// time (index 2) at any edge where csr_we is high; other indexes are ignored.
// Registers should be written only while no word is in flight.
// Synchronous reset clears the pipeline, restores speed 50, brightness 100 and
// start time 0. The receiver cannot stall, so results are never held back.
module hue_rotation_color_generator #(
   parameter int HUE_FRAC_BITS = hrcg_pkg::HUE_FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_start,
   output logic                            busy,
   input  logic [hrcg_pkg::TIME_W-1:0]     req_now_time_us,
   output logic                            rsp_valid,
   output logic [hrcg_pkg::CH_W-1:0]       rsp_red_level,
   output logic [hrcg_pkg::CH_W-1:0]       rsp_green_level,
   output logic [hrcg_pkg::CH_W-1:0]       rsp_blue_level,
   input  logic                            csr_we,
   input  logic [hrcg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hrcg_pkg::TIME_W-1:0]     csr_wdata
);
   import hrcg_pkg::*;

   localparam int F      = HUE_FRAC_BITS;
   localparam int V_W    = F + 6;
   localparam int P1_W   = M_W + SQ_W;
   localparam int T_W    = M_W + DEG_W;
   localparam int X4_W   = M_W + F;
   localparam int Q3_W   = T_W - DIV_DROP;
   localparam int Q4_W   = X4_W - DIV_DROP;
   localparam logic [V_W-1:0] SPAN = {6'd60, {F{1'b0}}};

   typedef enum logic [2:0] {
      SEC_RED     = 3'd0,
      SEC_YELLOW  = 3'd1,
      SEC_GREEN   = 3'd2,
      SEC_CYAN    = 3'd3,
      SEC_BLUE    = 3'd4,
      SEC_MAGENTA = 3'd5
   } sector_type;

   // Configuration.
   logic [SQ_W-1:0]   speed_sq_ff, speed_sq_in;
   logic [PCT_W-1:0]  bright_ff, bright_in;
   logic [TIME_W-1:0] start_ff;
   logic [PCT_W-1:0]  speed_sat;

   assign speed_sat   = sat_pct(csr_wdata[PCT_W-1:0]);
   assign speed_sq_in = (speed_sat == '0) ? SQ_W'(1)
                                          : SQ_W'(speed_sat) * SQ_W'(speed_sat);
   assign bright_in   = sat_pct(csr_wdata[PCT_W-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_sq_ff <= SPEED_SQ_RESET;
         bright_ff   <= BRIGHT_RESET;
         start_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SPEED:  speed_sq_ff <= speed_sq_in;
            CSR_BRIGHT: bright_ff   <= bright_in;
            CSR_START:  start_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // Elapsed time, reduction, speed scaling and degree scaling.
   logic              s0_valid_ff, s1_valid_ff, s2_valid_ff;
   logic [TIME_W-1:0] elapsed_ff;
   logic              d1_valid, d2_valid, d3_valid, d4_valid;
   logic [M_W-1:0]    r1, r2, r3, r4;
   logic [P1_W-1:0]   prod_ff;
   logic [T_W-1:0]    t_ff;
   logic [Q3_W-1:0]   q3;
   logic [Q4_W-1:0]   q4;
   logic [DEG_W-1:0]  deg_dly_ff [DIV_STAGES];

   hrcg_div #(.XW(TIME_W)) u_div_elapsed (
      .clock(clock), .reset(reset), .in_valid(s0_valid_ff), .x_in(elapsed_ff),
      .out_valid(d1_valid), .q_out(), .r_out(r1)
   );

   hrcg_div #(.XW(P1_W)) u_div_phase (
      .clock(clock), .reset(reset), .in_valid(s1_valid_ff), .x_in(prod_ff),
      .out_valid(d2_valid), .q_out(), .r_out(r2)
   );

   hrcg_div #(.XW(T_W)) u_div_degree (
      .clock(clock), .reset(reset), .in_valid(s2_valid_ff), .x_in(t_ff),
      .out_valid(d3_valid), .q_out(q3), .r_out(r3)
   );

   hrcg_div #(.XW(X4_W)) u_div_frac (
      .clock(clock), .reset(reset), .in_valid(d3_valid), .x_in({r3, {F{1'b0}}}),
      .out_valid(d4_valid), .q_out(q4), .r_out(r4)
   );

   // Color stages.
   logic                c1_valid_ff, c2_valid_ff, c3_valid_ff, c4_valid_ff;
   logic [19:0]         sec_prod;
   sector_type          sector_c1_in, sector_c1_ff, sector_c2_ff, sector_c3_ff;
   logic [DEG_W-1:0]    deg_c1_ff;
   logic [F-1:0]        frac_c1_ff;
   logic [DEG_W-1:0]    sec60, wdeg;
   logic [V_W-1:0]      w_fix, hue_v;
   logic [V_W+7:0]      z255;
   logic [Z_W-1:0]      z_in, z_ff;
   logic [28:0]         zx;
   logic [CH_W-1:0]     x_in, x_ff;
   logic [CH_W-1:0]     red_c, green_c, blue_c;
   logic [SCALE_W-1:0]  red_y_ff, green_y_ff, blue_y_ff;
   logic [29:0]         red_p, green_p, blue_p;
   logic                rsp_valid_ff;
   logic [CH_W-1:0]     red_ff, green_ff, blue_ff;

   assign sec_prod     = 20'(deg_dly_ff[DIV_STAGES-1]) * 20'(SECTOR_RECIP);
   assign sector_c1_in = sector_type'(sec_prod[SECTOR_SHIFT+2:SECTOR_SHIFT]);

   assign sec60  = DEG_W'(sector_c1_ff) * DEG_SECTOR;
   assign wdeg   = deg_c1_ff - sec60;
   assign w_fix  = {wdeg[5:0], frac_c1_ff};
   assign hue_v  = sector_c1_ff[0] ? (SPAN - w_fix) : w_fix;
   assign z255   = {hue_v, 8'b0} - (V_W+8)'(hue_v);
   assign z_in   = z255[F+Z_W-1:F];

   assign zx   = 29'(z_ff) * 29'(DIV60_RECIP);
   assign x_in = zx[DIV60_SHIFT+CH_W-1:DIV60_SHIFT];

   always_comb begin
      case (sector_c3_ff)
         SEC_RED:    begin red_c = CH_MAX; green_c = x_ff;   blue_c = '0;     end
         SEC_YELLOW: begin red_c = x_ff;   green_c = CH_MAX; blue_c = '0;     end
         SEC_GREEN:  begin red_c = '0;     green_c = CH_MAX; blue_c = x_ff;   end
         SEC_CYAN:   begin red_c = '0;     green_c = x_ff;   blue_c = CH_MAX; end
         SEC_BLUE:   begin red_c = x_ff;   green_c = '0;     blue_c = CH_MAX; end
         default:    begin red_c = CH_MAX; green_c = '0;     blue_c = x_ff;   end
      endcase
   end

   // Full brightness scales by 100/100, which leaves each channel unchanged.
   assign red_p   = 30'(red_y_ff)   * 30'(DIV100_RECIP);
   assign green_p = 30'(green_y_ff) * 30'(DIV100_RECIP);
   assign blue_p  = 30'(blue_y_ff)  * 30'(DIV100_RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         c1_valid_ff  <= 1'b0;
         c2_valid_ff  <= 1'b0;
         c3_valid_ff  <= 1'b0;
         c4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= req_start && !busy;
         s1_valid_ff  <= d1_valid;
         s2_valid_ff  <= d2_valid;
         c1_valid_ff  <= d4_valid;
         c2_valid_ff  <= c1_valid_ff;
         c3_valid_ff  <= c2_valid_ff;
         c4_valid_ff  <= c3_valid_ff;
         rsp_valid_ff <= c4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      elapsed_ff    <= req_now_time_us - start_ff;
      prod_ff       <= P1_W'(r1) * P1_W'(speed_sq_ff);
      t_ff          <= T_W'(r2) * T_W'(DEG_FULL);
      deg_dly_ff[0] <= q3[DEG_W-1:0];
      for (int i = 1; i < DIV_STAGES; i++) begin
         deg_dly_ff[i] <= deg_dly_ff[i-1];
      end
      sector_c1_ff <= sector_c1_in;
      deg_c1_ff    <= deg_dly_ff[DIV_STAGES-1];
      frac_c1_ff   <= q4[F-1:0];
      sector_c2_ff <= sector_c1_ff;
      z_ff         <= z_in;
      sector_c3_ff <= sector_c2_ff;
      x_ff         <= x_in;
      red_y_ff     <= SCALE_W'(red_c)   * SCALE_W'(bright_ff);
      green_y_ff   <= SCALE_W'(green_c) * SCALE_W'(bright_ff);
      blue_y_ff    <= SCALE_W'(blue_c)  * SCALE_W'(bright_ff);
      red_ff       <= red_p[DIV100_SHIFT+CH_W-1:DIV100_SHIFT];
      green_ff     <= green_p[DIV100_SHIFT+CH_W-1:DIV100_SHIFT];
      blue_ff      <= blue_p[DIV100_SHIFT+CH_W-1:DIV100_SHIFT];
   end

   // The final remainder is never needed; it is folded in here so nothing dangles.
   logic unused_r4;
   assign unused_r4 = ^r4;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_red_level   = red_ff;
   assign rsp_green_level = green_ff;
   assign rsp_blue_level  = blue_ff;

endmodule

// ===== hw/rtl/hrcg_check.sv =====
`include "hue_rotation_color_generator_macros.svh"

module hrcg_check (
   input logic clock,
   input logic reset,
   input logic req_start,
   input logic busy,
   input logic rsp_valid
);
   import hrcg_pkg::*;

   // Every accepted word gives exactly one color, and every color comes from an accepted word.
   `HRCG_ASSERT_IMP(a_word_gives_color, clock, reset, req_start && !busy, ##PIPE_LATENCY rsp_valid)
   `HRCG_ASSERT_IMP(a_color_has_word, clock, reset, rsp_valid, $past(req_start && !busy, PIPE_LATENCY))
   `HRCG_ASSERT_NEXT(a_reset_flushes, clock, reset, !rsp_valid)

endmodule

bind hue_rotation_color_generator hrcg_check u_hrcg_check (
   .clock(clock),
   .reset(reset),
   .req_start(req_start),
   .busy(busy),
   .rsp_valid(rsp_valid)
);
